### hw/rtl/cll_pkg.sv
// Package for the cursor linked list engine: request/result types, codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package cll_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int FIELD_W       = 5;

    typedef enum logic [1:0] {
        CMD_FRONT  = 2'd0,
        CMD_END    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        t_command   command;
        logic [7:0] data;
    } t_request;

    typedef struct packed {
        t_status              status;
        logic [FIELD_W-1:0]   slot;
        logic [FIELD_W-1:0]   list_head;
        logic [FIELD_W-1:0]   free_head;
    } t_result;

    typedef struct packed {
        logic    load;
        logic    alloc_rd;
        logic    alloc_commit;
        logic    walk_step;
        logic    walk_tail;
        logic    del_start;
        logic    del_step;
        logic    del_unlink;
        logic    del_free;
        logic    emit;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_command command;
        logic     free_none;
        logic     head_none;
        logic     link_more;
        logic     next_ok;
        logic     elem_match;
    } t_dp_stat;

endpackage

### hw/rtl/cll_datapath.sv
// Datapath of the cursor linked list engine: pointers, walk counter,
// element and link memories, result register. Depends on cll_pkg.
module cll_datapath #(
    parameter int SLOTS = cll_pkg::SLOTS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cll_pkg::t_request i_request,
    input  cll_pkg::t_dp_cmd  i_cmd,
    output cll_pkg::t_dp_stat o_stat,
    output logic              o_strobe,
    output cll_pkg::t_result  o_result
);
    import cll_pkg::*;

    localparam int PW = $clog2(SLOTS + 1);
    localparam int AW = $clog2(SLOTS);
    localparam logic [PW-1:0] NONE     = PW'(SLOTS);
    localparam logic [PW-1:0] TOP_SLOT = PW'(SLOTS - 1);

    logic [PW-1:0] r_link_mem [SLOTS];
    logic [7:0]    r_elem_mem [SLOTS];

    t_command      r_cmd;
    logic [7:0]    r_data;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_free;
    logic [PW-1:0] r_mark;
    logic [PW-1:0] r_t;
    logic [PW-1:0] r_cur;
    logic [PW-1:0] r_prev;
    logic [PW-1:0] r_slot;
    logic [PW-1:0] r_n;
    logic [PW-1:0] r_link_q;
    logic [7:0]    r_elem_q;
    logic [PW-1:0] r_rd_addr;
    logic          r_rd_pristine;
    logic          r_strobe;
    t_result       r_result;

    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] wr_data;
    logic [PW-1:0] link_rd;

    // untouched slots below the mark still hold their reset link
    assign link_rd = r_rd_pristine ? ((r_rd_addr == '0) ? NONE : r_rd_addr - 1'b1)
                                   : r_link_q;

    always_comb begin
        rd_en   = i_cmd.alloc_rd || i_cmd.walk_step || i_cmd.del_start || i_cmd.del_step
                  || (i_cmd.alloc_commit && (r_head < NONE));
        rd_addr = r_head;
        if (i_cmd.alloc_rd) begin
            rd_addr = r_free;
        end else if (i_cmd.walk_step || i_cmd.del_step) begin
            rd_addr = link_rd;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_free;
        wr_data = NONE;
        if (i_cmd.alloc_commit) begin
            wr_en   = 1'b1;
            wr_addr = r_free;
            wr_data = (r_cmd == CMD_FRONT) ? r_head : NONE;
        end else if (i_cmd.walk_tail) begin
            wr_en   = 1'b1;
            wr_addr = r_t;
            wr_data = r_slot;
        end else if (i_cmd.del_unlink) begin
            wr_en   = (r_prev < NONE);
            wr_addr = r_prev;
            wr_data = link_rd;
        end else if (i_cmd.del_free) begin
            wr_en   = 1'b1;
            wr_addr = r_cur;
            wr_data = r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (i_cmd.alloc_commit) begin
            r_elem_mem[r_free[AW-1:0]] <= r_data;
        end
        if (rd_en) begin
            r_link_q      <= r_link_mem[rd_addr[AW-1:0]];
            r_elem_q      <= r_elem_mem[rd_addr[AW-1:0]];
            r_rd_addr     <= rd_addr;
            r_rd_pristine <= (rd_addr < r_mark);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= NONE;
            r_free   <= TOP_SLOT;
            r_mark   <= NONE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.alloc_commit) begin
                r_free <= link_rd;
                if (r_free < r_mark) begin
                    r_mark <= r_free;
                end
                if ((r_cmd == CMD_FRONT) || !(r_head < NONE)) begin
                    r_head <= r_free;
                end
            end
            if (i_cmd.del_unlink && !(r_prev < NONE)) begin
                r_head <= link_rd;
            end
            if (i_cmd.del_free) begin
                r_free <= r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_request.command;
            r_data <= i_request.data;
            r_slot <= NONE;
        end
        if (i_cmd.alloc_commit) begin
            r_slot <= r_free;
            r_t    <= r_head;
            r_n    <= '0;
        end
        if (i_cmd.walk_step) begin
            r_t <= link_rd;
            r_n <= r_n + 1'b1;
        end
        if (i_cmd.del_start) begin
            r_cur  <= r_head;
            r_prev <= NONE;
            r_n    <= '0;
        end
        if (i_cmd.del_step) begin
            r_prev <= r_cur;
            r_cur  <= link_rd;
            r_n    <= r_n + 1'b1;
        end
        if (i_cmd.del_free) begin
            r_slot <= r_cur;
        end
        if (i_cmd.emit) begin
            r_result.status    <= i_cmd.status;
            r_result.slot      <= FIELD_W'(r_slot);
            r_result.list_head <= FIELD_W'(r_head);
            r_result.free_head <= FIELD_W'(r_free);
        end
    end

    assign o_stat.command    = r_cmd;
    assign o_stat.free_none  = !(r_free < NONE);
    assign o_stat.head_none  = !(r_head < NONE);
    assign o_stat.link_more  = (link_rd < NONE) && (r_n < NONE);
    assign o_stat.next_ok    = (link_rd < NONE) && (r_n < TOP_SLOT);
    assign o_stat.elem_match = (r_elem_q == r_data);

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### hw/rtl/cll_ctrl.sv
// Controller of the cursor linked list engine: one-hot sequencer that
// drives the datapath commands. Depends on cll_pkg.
module cll_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cll_pkg::t_dp_stat i_stat,
    output logic              o_busy,
    output cll_pkg::t_dp_cmd  o_cmd
);
    import cll_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_COMMIT   = 8'b0000_0100,
        S_WALK     = 8'b0000_1000,
        S_DEL_WALK = 8'b0001_0000,
        S_DEL_FREE = 8'b0010_0000,
        S_DONE     = 8'b0100_0000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_status   = ST_OK;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.command)
                    CMD_FRONT, CMD_END: begin
                        if (i_stat.free_none) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.alloc_rd = 1'b1;
                            n_state        = S_COMMIT;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.head_none) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.del_start = 1'b1;
                            n_state         = S_DEL_WALK;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_COMMIT: begin
                o_cmd.alloc_commit = 1'b1;
                if ((i_stat.command == CMD_END) && !i_stat.head_none) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                if (i_stat.link_more) begin
                    o_cmd.walk_step = 1'b1;
                end else begin
                    o_cmd.walk_tail = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DEL_WALK: begin
                priority if (i_stat.elem_match) begin
                    o_cmd.del_unlink = 1'b1;
                    n_state          = S_DEL_FREE;
                end else if (i_stat.next_ok) begin
                    o_cmd.del_step = 1'b1;
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_DEL_FREE: begin
                o_cmd.del_free = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hw/rtl/cursor_linked_list_engine.sv
// Top level of the cursor linked list engine: sequencer plus datapath.
// Depends on cll_pkg, cll_ctrl and cll_datapath.
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+----------------------------------
//  request  | i_request (command, data)   | taken at edge with start && !busy
//  result   | o_result (status, slot,     | o_strobe high for one cycle,
//           |  list_head, free_head)      | taken at the edge ending it
//
// busy stays high until the result. A no-op, a full pool or a delete on an
// empty list goes from decode straight to done; an insert at the front or
// into an empty list passes decode, commit and done. An insert at the end
// also walks the list, reading each node on the way to the tail; a delete
// walks it until a node matches or the list ends. The link memory's single
// registered read port sets one node per cycle. The result strobe follows in
// the cycle busy falls. Reset is synchronous and active low; it restores the
// empty list and full free chain at once. The receiver cannot stall results.
module cursor_linked_list_engine #(
    parameter int SLOTS = cll_pkg::SLOTS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cll_pkg::t_request i_request,
    output logic              o_strobe,
    output cll_pkg::t_result  o_result
);
    import cll_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    cll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_cmd   (dp_cmd)
    );

    cll_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_cmd     (dp_cmd),
        .o_stat    (dp_stat),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for cursor_linked_list_engine: a queue-fed driver,
// a strobe monitor and a slot-pool predictor. Depends on cll_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import cll_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [FIELD_W-1:0] NONE_LINK = FIELD_W'(SLOTS);
    localparam int RANDOM_REQUESTS = 925;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        t_request req;
        bit       hold;
    } t_pending;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_request req_bus = '0;
    logic     o_strobe;
    t_result  o_result;

    t_pending pending_requests[$];
    t_result  expected_results[$];
    logic [7:0] shadow_bytes[$];

    logic [7:0]         element_mem[SLOTS];
    logic [FIELD_W-1:0] link_mem[SLOTS];
    logic [FIELD_W-1:0] free_ptr;
    logic [FIELD_W-1:0] head_ptr;

    int error_count = 0;
    int accepted_total = 0;
    int results_seen = 0;
    int gap_left = 0;
    int gap_pick;
    int idle_cycles = 0;
    logic next_start;
    t_pending next_item;
    t_result want;

    cursor_linked_list_engine #(
        .SLOTS(SLOTS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_request(req_bus),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
        error_count++;
    endtask

    function automatic t_result predict_list_op(input t_request req);
        t_result            res;
        logic [FIELD_W-1:0] s;
        logic [FIELD_W-1:0] t;
        logic [FIELD_W-1:0] prev;
        logic [FIELD_W-1:0] cur;
        int                 n;
        res.status = ST_OK;
        res.slot   = NONE_LINK;
        case (req.command)
            CMD_FRONT, CMD_END: begin
                s = free_ptr;
                if (s >= NONE_LINK) begin
                    res.status = ST_FULL;
                end else begin
                    free_ptr       = link_mem[s];
                    element_mem[s] = req.data;
                    res.slot       = s;
                    if (req.command == CMD_FRONT || head_ptr >= NONE_LINK) begin
                        link_mem[s] = (req.command == CMD_FRONT) ? head_ptr : NONE_LINK;
                        head_ptr    = s;
                    end else begin
                        t           = head_ptr;
                        n           = 0;
                        link_mem[s] = NONE_LINK;
                        while (link_mem[t] < NONE_LINK && n < SLOTS) begin
                            t = link_mem[t];
                            n++;
                        end
                        link_mem[t] = s;
                    end
                end
            end
            CMD_DELETE: begin
                prev = NONE_LINK;
                cur  = head_ptr;
                n    = 0;
                while (cur < NONE_LINK && n < SLOTS && element_mem[cur] != req.data) begin
                    prev = cur;
                    cur  = link_mem[cur];
                    n++;
                end
                if (cur < NONE_LINK && n < SLOTS) begin
                    if (prev < NONE_LINK) link_mem[prev] = link_mem[cur];
                    else head_ptr = link_mem[cur];
                    link_mem[cur] = free_ptr;
                    free_ptr      = cur;
                    res.slot      = cur;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        res.list_head = head_ptr;
        res.free_head = free_ptr;
        return res;
    endfunction

    task automatic queue_request(input t_command cmd, input logic [7:0] data, input bit hold);
        t_pending item;
        int       idx;
        item.req.command = cmd;
        item.req.data    = data;
        item.hold        = hold;
        pending_requests.push_back(item);
        if ((cmd == CMD_FRONT || cmd == CMD_END) && shadow_bytes.size() < SLOTS) begin
            shadow_bytes.push_back(data);
        end else if (cmd == CMD_DELETE) begin
            for (idx = 0; idx < shadow_bytes.size(); idx++) begin
                if (shadow_bytes[idx] == data) begin
                    shadow_bytes.delete(idx);
                    break;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                expected_results.push_back(predict_list_op(req_bus));
                accepted_total++;
                next_start = 1'b0;
                gap_pick = $urandom_range(0, 19);
                if (gap_pick < 10) gap_left = 0;
                else if (gap_pick < 16) gap_left = $urandom_range(1, 3);
                else if (gap_pick < 19) gap_left = $urandom_range(4, 10);
                else gap_left = $urandom_range(20, 40);
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0 &&
                             (!pending_requests[0].hold || accepted_total == results_seen)) begin
                    next_item = pending_requests.pop_front();
                    req_bus <= next_item.req;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, status", o_result.status, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", o_result.status, want.status);
                if (o_result.slot !== want.slot)
                    report_mismatch("slot", o_result.slot, want.slot);
                if (o_result.list_head !== want.list_head)
                    report_mismatch("list_head", o_result.list_head, want.list_head);
                if (o_result.free_head !== want.free_head)
                    report_mismatch("free_head", o_result.free_head, want.free_head);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", IDLE_LIMIT);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] byte_pool[8];
        t_command   cmd;
        logic [7:0] data;
        int         i;
        int         pick;
        bit         insert_heavy;

        for (i = 0; i < SLOTS; i++) begin
            element_mem[i] = '0;
            link_mem[i]    = (i == 0) ? NONE_LINK : FIELD_W'(i - 1);
        end
        free_ptr = FIELD_W'(SLOTS - 1);
        head_ptr = NONE_LINK;
        for (i = 0; i < 8; i++) byte_pool[i] = 8'($urandom);

        queue_request(CMD_DELETE, 8'h12, 1'b0);
        queue_request(CMD_NOP,    8'hFF, 1'b0);
        queue_request(CMD_FRONT,  8'h00, 1'b0);
        queue_request(CMD_END,    8'hFF, 1'b0);
        queue_request(CMD_FRONT,  8'h55, 1'b0);
        queue_request(CMD_END,    8'hAA, 1'b0);
        queue_request(CMD_END,    8'h55, 1'b0);
        queue_request(CMD_DELETE, 8'h55, 1'b0);
        queue_request(CMD_DELETE, 8'hAA, 1'b0);
        queue_request(CMD_DELETE, 8'h33, 1'b0);
        for (i = 0; i < 13; i++)
            queue_request(i[0] ? CMD_END : CMD_FRONT, 8'(i * 17 + 1), 1'b0);
        queue_request(CMD_FRONT,  8'h80, 1'b0);
        queue_request(CMD_END,    8'h7F, 1'b0);
        queue_request(CMD_DELETE, 8'h55, 1'b0);

        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            insert_heavy = ((i / 60) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < 3) cmd = CMD_NOP;
            else if (pick < (insert_heavy ? 70 : 35)) cmd = $urandom_range(0, 1) ? CMD_END : CMD_FRONT;
            else cmd = CMD_DELETE;
            if (cmd == CMD_DELETE && shadow_bytes.size() > 0 && $urandom_range(0, 3) != 0)
                data = shadow_bytes[$urandom_range(0, shadow_bytes.size() - 1)];
            else if ($urandom_range(0, 1))
                data = byte_pool[$urandom_range(0, 7)];
            else
                data = 8'($urandom);
            queue_request(cmd, data, (i % 150) == 0);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_requests.size() == 0 && !start && accepted_total == results_seen);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned", 0, expected_results.size());
        if (error_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/cll_pkg.sv
hw/rtl/cll_datapath.sv
hw/rtl/cll_ctrl.sv
hw/rtl/cursor_linked_list_engine.sv
tb/tb.sv
